>>> rtl/arpr_pkg.sv
// ----------------------------------------------------------------------------
// ARP resolver package
// Shared types, codes and frame layout helpers for the ARP resolver blocks.
// ----------------------------------------------------------------------------
package arpr_pkg;

  localparam int MAC_W      = 48;
  localparam int IP_W       = 32;
  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int OPCODE_W   = 3;
  localparam int KIND_W     = 2;
  localparam int POS_W      = 6;

  localparam logic [POS_W-1:0] FRAME_LAST   = 6'd59;
  localparam logic [POS_W-1:0] RX_MIN_LAST  = 6'd41;
  localparam logic [POS_W-1:0] RX_POS_MAX   = 6'd63;

  localparam logic [7:0] BCAST_BYTE     = 8'hff;
  localparam logic [7:0] ETYPE_ARP_HI   = 8'h08;
  localparam logic [7:0] ETYPE_ARP_LO   = 8'h06;
  localparam logic [7:0] HTYPE_ETH_HI   = 8'h00;
  localparam logic [7:0] HTYPE_ETH_LO   = 8'h01;
  localparam logic [7:0] PTYPE_IP4_HI   = 8'h08;
  localparam logic [7:0] PTYPE_IP4_LO   = 8'h00;
  localparam logic [7:0] HLEN_ETH       = 8'h06;
  localparam logic [7:0] PLEN_IP4       = 8'h04;
  localparam logic [7:0] ARP_OP_HI      = 8'h00;
  localparam logic [7:0] ARP_OP_REQUEST = 8'h01;
  localparam logic [7:0] ARP_OP_REPLY   = 8'h02;

  typedef enum logic [OPCODE_W-1:0] {
    OP_START  = 3'd0,
    OP_TICK   = 3'd1,
    OP_RX     = 3'd2,
    OP_GRAT   = 3'd3,
    OP_CANCEL = 3'd4
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TX       = 2'd0,
    KIND_RESOLVED = 2'd1,
    KIND_TIMEOUT  = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_MAC    = 3'd0,
    CFG_OWN_IP     = 3'd1,
    CFG_DEST_IP    = 3'd2,
    CFG_GATEWAY_IP = 3'd3,
    CFG_GW_ENABLE  = 3'd4,
    CFG_RETRY      = 3'd5,
    CFG_TIMEOUT    = 3'd6
  } cfg_idx_t;

  // Result request handed from the control logic to the output stage.
  typedef struct packed {
    logic             load;
    logic             frame;
    logic             grat;
    kind_t            kind;
    logic [MAC_W-1:0] mac;
  } res_req_t;

  // Parser report for the byte being consumed.
  typedef struct packed {
    logic             hit;
    logic [MAC_W-1:0] mac;
  } rx_status_t;

  // One byte of an outgoing ARP frame (request, or gratuitous reply).
  function automatic logic [7:0] frame_byte(input logic [POS_W-1:0] idx,
                                            input logic             grat,
                                            input logic [MAC_W-1:0] mac,
                                            input logic [IP_W-1:0]  ip,
                                            input logic [IP_W-1:0]  tip);
    logic [MAC_W-1:0] tha;
    logic [IP_W-1:0]  tpa;
    logic [7:0]       b;
    tha = grat ? mac : '0;
    tpa = grat ? ip : tip;
    case (idx) inside
      [6'd0:6'd5]:   b = BCAST_BYTE;
      [6'd6:6'd11]:  b = mac[8*(11-idx) +: 8];
      6'd12:         b = ETYPE_ARP_HI;
      6'd13:         b = ETYPE_ARP_LO;
      6'd14:         b = HTYPE_ETH_HI;
      6'd15:         b = HTYPE_ETH_LO;
      6'd16:         b = PTYPE_IP4_HI;
      6'd17:         b = PTYPE_IP4_LO;
      6'd18:         b = HLEN_ETH;
      6'd19:         b = PLEN_IP4;
      6'd20:         b = ARP_OP_HI;
      6'd21:         b = grat ? ARP_OP_REPLY : ARP_OP_REQUEST;
      [6'd22:6'd27]: b = mac[8*(27-idx) +: 8];
      [6'd28:6'd31]: b = ip[8*(31-idx) +: 8];
      [6'd32:6'd37]: b = tha[8*(37-idx) +: 8];
      [6'd38:6'd41]: b = tpa[8*(41-idx) +: 8];
      default:       b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/arpr_in_if.sv
// ----------------------------------------------------------------------------
// ARP resolver command channel
// Valid/ready channel carrying one command item per transfer.
// ----------------------------------------------------------------------------
interface arpr_in_if;
  import arpr_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [7:0]          rx_byte;
  logic                rx_last;

  modport source (output valid, opcode, rx_byte, rx_last, input ready);
  modport sink   (input valid, opcode, rx_byte, rx_last, output ready);
endinterface

>>> rtl/arpr_out_if.sv
// ----------------------------------------------------------------------------
// ARP resolver result channel
// Valid/ready channel carrying one result item per transfer.
// ----------------------------------------------------------------------------
interface arpr_out_if;
  import arpr_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [7:0]        tx_byte;
  logic              tx_last;
  logic [MAC_W-1:0]  peer_mac;

  modport source (output valid, kind, tx_byte, tx_last, peer_mac, input ready);
  modport sink   (input valid, kind, tx_byte, tx_last, peer_mac, output ready);
endinterface

>>> rtl/arpr_rx_parser.sv
// ----------------------------------------------------------------------------
// ARP reply parser
// Checks received frame bytes on the fly and captures the sender MAC.
// ----------------------------------------------------------------------------
module arpr_rx_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rx_fire,
  input  logic [7:0]                rx_byte,
  input  logic                      rx_last,
  input  logic [arpr_pkg::IP_W-1:0] tgt_ip,
  input  logic [arpr_pkg::IP_W-1:0] own_ip,
  output arpr_pkg::rx_status_t      status
);
  import arpr_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             match_r, match_nxt;
  logic [MAC_W-1:0] mac_r, mac_nxt;
  logic             byte_ok;
  logic [1:0]       k_tgt, k_own;
  logic [POS_W-1:0] own_off;

  assign k_tgt   = pos_r[1:0];
  assign own_off = pos_r - 6'd38;
  assign k_own   = own_off[1:0];

  always_comb begin
    byte_ok = 1'b1;
    mac_nxt = mac_r;
    case (pos_r) inside
      6'd12:         byte_ok = (rx_byte == ETYPE_ARP_HI);
      6'd13:         byte_ok = (rx_byte == ETYPE_ARP_LO);
      6'd20:         byte_ok = (rx_byte == ARP_OP_HI);
      6'd21:         byte_ok = (rx_byte == ARP_OP_REPLY);
      [6'd22:6'd27]: mac_nxt = {mac_r[MAC_W-9:0], rx_byte};
      [6'd28:6'd31]: byte_ok = (rx_byte == tgt_ip[{~k_tgt, 3'b000} +: 8]);
      [6'd38:6'd41]: byte_ok = (rx_byte == own_ip[{~k_own, 3'b000} +: 8]);
      default:       byte_ok = 1'b1;
    endcase
  end

  assign status.hit = rx_fire && rx_last && match_r && byte_ok && (pos_r >= RX_MIN_LAST);
  assign status.mac = mac_nxt;

  always_comb begin
    pos_nxt   = pos_r;
    match_nxt = match_r;
    if (rx_fire) begin
      if (rx_last) begin
        pos_nxt   = '0;
        match_nxt = 1'b1;
      end else begin
        match_nxt = match_r && byte_ok;
        if (pos_r != RX_POS_MAX) begin
          pos_nxt = pos_r + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      match_r <= 1'b1;
      mac_r   <= '0;
    end else begin
      pos_r   <= pos_nxt;
      match_r <= match_nxt;
      if (rx_fire) begin
        mac_r <= rx_last ? '0 : mac_nxt;
      end
    end
  end

endmodule

>>> rtl/arpr_out_stage.sv
// ----------------------------------------------------------------------------
// ARP resolver output stage
// Result register plus a byte counter that plays out 60-byte ARP frames.
// ----------------------------------------------------------------------------
module arpr_out_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  arpr_pkg::res_req_t         req,
  output logic                       req_ready,
  input  logic [arpr_pkg::MAC_W-1:0] own_mac,
  input  logic [arpr_pkg::IP_W-1:0]  own_ip,
  input  logic [arpr_pkg::IP_W-1:0]  tgt_ip,
  arpr_out_if.source                 out_if
);
  import arpr_pkg::*;

  logic             out_valid_r, out_valid_nxt;
  kind_t            kind_r, kind_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             last_r, last_nxt;
  logic [MAC_W-1:0] mac_r, mac_nxt;
  logic             busy_r, busy_nxt;
  logic [POS_W-1:0] idx_r, idx_nxt;
  logic             grat_r, grat_nxt;
  logic             load_ok;
  logic [POS_W-1:0] fb_idx;
  logic             fb_grat;
  logic [7:0]       fb_byte;

  assign load_ok   = !out_valid_r || out_if.ready;
  assign req_ready = !busy_r && load_ok;

  assign fb_idx  = busy_r ? idx_r : '0;
  assign fb_grat = busy_r ? grat_r : req.grat;
  assign fb_byte = frame_byte(fb_idx, fb_grat, own_mac, own_ip, tgt_ip);

  always_comb begin
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    mac_nxt       = mac_r;
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    grat_nxt      = grat_r;
    if (busy_r && load_ok) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = KIND_TX;
      byte_nxt      = fb_byte;
      last_nxt      = (idx_r == FRAME_LAST);
      mac_nxt       = '0;
      idx_nxt       = idx_r + 6'd1;
      busy_nxt      = (idx_r != FRAME_LAST);
    end else if (req.load && req_ready) begin
      out_valid_nxt = 1'b1;
      if (req.frame) begin
        kind_nxt = KIND_TX;
        byte_nxt = fb_byte;
        last_nxt = 1'b0;
        mac_nxt  = '0;
        busy_nxt = 1'b1;
        idx_nxt  = 6'd1;
        grat_nxt = req.grat;
      end else begin
        kind_nxt = req.kind;
        byte_nxt = 8'h00;
        last_nxt = 1'b0;
        mac_nxt  = (req.kind == KIND_RESOLVED) ? req.mac : '0;
      end
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      idx_r       <= '0;
      grat_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      grat_r      <= grat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    mac_r  <= mac_nxt;
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.kind     = kind_r;
  assign out_if.tx_byte  = byte_r;
  assign out_if.tx_last  = last_r;
  assign out_if.peer_mac = mac_r;

  // The frame counter only runs between the first and the last byte.
  a_busy_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r != '0) && (idx_r <= FRAME_LAST))
    else $error("frame counter out of range while busy");

  // An end-of-frame marker only ever travels with a transmit byte.
  a_last_is_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && last_r) |-> (kind_r == KIND_TX))
    else $error("tx_last set on a non-transmit result");

  // Loading the last byte of a frame frees the stage.
  a_frame_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && load_ok && (idx_r == FRAME_LAST)) |=> !busy_r)
    else $error("frame playout did not end after the last byte");

endmodule

>>> rtl/arp_resolver_with_retry_core.sv
// ----------------------------------------------------------------------------
// ARP resolver with retry and timeout
// Sends ARP requests for the configured target, re-sends them on a retry
// interval, gives up at a timeout and reports the MAC from a matching reply.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Carries
//   in_if     in         valid/ready        opcode, rx_byte, rx_last
//   out_if    out        valid/ready        kind, tx_byte, tx_last, peer_mac
//   cfg_*     in         write enable only  register index and write data
//
// A command is registered on input, so commands that give no result, or a
// single result, flow at one per cycle unless the output stalls. A start or
// gratuitous command plays out 60 frame bytes, one per cycle unless the
// output stalls, from the output stage's byte counter; further commands wait
// during playout. Reset is synchronous and active low; it idles the resolver
// and resets its state and configuration registers. A stalled result holds in
// the output register while one more command can enter the input register.
//
module arp_resolver_with_retry_core #(
  parameter int TICK_COUNT_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  arpr_in_if.sink                         in_if,
  arpr_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [arpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arpr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import arpr_pkg::*;

  // Compare and add width: wide enough for both the tick counters and the
  // 32-bit interval registers.
  localparam int TW = TICK_COUNT_WIDTH;
  localparam int CW = (TW > IP_W) ? TW : IP_W;
  localparam logic [CW:0] TICK_MAX = {{(CW + 1 - TW){1'b0}}, {TW{1'b1}}};

  // Configuration registers.
  logic [MAC_W-1:0] own_mac_r;
  logic [IP_W-1:0]  own_ip_r;
  logic [IP_W-1:0]  dest_ip_r;
  logic [IP_W-1:0]  gateway_ip_r;
  logic             gw_enable_r;
  logic [IP_W-1:0]  retry_r;
  logic [IP_W-1:0]  timeout_r;
  logic [IP_W-1:0]  tgt_ip;

  // Input register.
  logic       inq_valid_r;
  opcode_t    inq_op_r;
  logic [7:0] inq_byte_r;
  logic       inq_last_r;
  logic       proc_fire;

  // Resolution state.
  logic          active_r, active_nxt;
  logic [TW-1:0] elapsed_r, elapsed_nxt;
  logic [TW-1:0] next_retry_r, next_retry_nxt;

  logic [CW:0]   tick_sum;
  logic [TW-1:0] elapsed_inc;
  logic [CW:0]   retry_sum;
  logic [TW-1:0] retry_at;
  logic [CW:0]   start_sum;
  logic [TW-1:0] start_at;

  res_req_t   req;
  logic       req_ready;
  logic       rx_fire;
  rx_status_t rx_status;

  assign tgt_ip = gw_enable_r ? gateway_ip_r : dest_ip_r;

  // Configuration writes; unused register indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r    <= '0;
      own_ip_r     <= '0;
      dest_ip_r    <= '0;
      gateway_ip_r <= '0;
      gw_enable_r  <= 1'b0;
      retry_r      <= 32'd500;
      timeout_r    <= 32'd3000;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_OWN_MAC:    own_mac_r    <= cfg_wdata[MAC_W-1:0];
        CFG_OWN_IP:     own_ip_r     <= cfg_wdata[IP_W-1:0];
        CFG_DEST_IP:    dest_ip_r    <= cfg_wdata[IP_W-1:0];
        CFG_GATEWAY_IP: gateway_ip_r <= cfg_wdata[IP_W-1:0];
        CFG_GW_ENABLE:  gw_enable_r  <= cfg_wdata[0];
        CFG_RETRY:      retry_r      <= cfg_wdata[IP_W-1:0];
        CFG_TIMEOUT:    timeout_r    <= cfg_wdata[IP_W-1:0];
        default:        ;
      endcase
    end
  end

  // The input register takes a new command whenever the held one is processed
  // in the same cycle, so a steady stream sees no bubbles.
  assign proc_fire   = inq_valid_r && req_ready;
  assign in_if.ready = !inq_valid_r || proc_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      inq_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      inq_op_r   <= opcode_t'(in_if.opcode);
      inq_byte_r <= in_if.rx_byte;
      inq_last_r <= in_if.rx_last;
    end
  end

  // Saturating counter arithmetic. Both the timeout and retry checks use the
  // incremented elapsed count.
  assign tick_sum    = {1'b0, CW'(elapsed_r)} + {{CW{1'b0}}, 1'b1};
  assign elapsed_inc = (tick_sum > TICK_MAX) ? TW'(TICK_MAX) : TW'(tick_sum);
  assign retry_sum   = {1'b0, CW'(elapsed_inc)} + {1'b0, CW'(retry_r)};
  assign retry_at    = (retry_sum > TICK_MAX) ? TW'(TICK_MAX) : TW'(retry_sum);
  assign start_sum   = {1'b0, CW'(retry_r)};
  assign start_at    = (start_sum > TICK_MAX) ? TW'(TICK_MAX) : TW'(start_sum);

  assign rx_fire = proc_fire && (inq_op_r == OP_RX);

  always_comb begin
    active_nxt     = active_r;
    elapsed_nxt    = elapsed_r;
    next_retry_nxt = next_retry_r;
    req            = '0;
    req.kind       = KIND_TX;
    if (proc_fire) begin
      case (inq_op_r)
        OP_START: begin
          active_nxt     = 1'b1;
          elapsed_nxt    = '0;
          next_retry_nxt = start_at;
          req.load       = 1'b1;
          req.frame      = 1'b1;
        end
        OP_TICK: begin
          // Ticks while idle do nothing; the timeout wins over a retry.
          if (active_r) begin
            elapsed_nxt = elapsed_inc;
            if (CW'(elapsed_inc) >= CW'(timeout_r)) begin
              active_nxt = 1'b0;
              req.load   = 1'b1;
              req.kind   = KIND_TIMEOUT;
            end else if (elapsed_inc >= next_retry_r) begin
              next_retry_nxt = retry_at;
              req.load       = 1'b1;
              req.frame      = 1'b1;
            end
          end
        end
        OP_RX: begin
          // A matching reply only counts while a resolution is running.
          if (rx_status.hit && active_r) begin
            active_nxt = 1'b0;
            req.load   = 1'b1;
            req.kind   = KIND_RESOLVED;
            req.mac    = rx_status.mac;
          end
        end
        OP_GRAT: begin
          req.load  = 1'b1;
          req.frame = 1'b1;
          req.grat  = 1'b1;
        end
        OP_CANCEL: begin
          active_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      elapsed_r    <= '0;
      next_retry_r <= '0;
    end else begin
      active_r     <= active_nxt;
      elapsed_r    <= elapsed_nxt;
      next_retry_r <= next_retry_nxt;
    end
  end

  arpr_rx_parser u_rx_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .rx_fire (rx_fire),
    .rx_byte (inq_byte_r),
    .rx_last (inq_last_r),
    .tgt_ip  (tgt_ip),
    .own_ip  (own_ip_r),
    .status  (rx_status)
  );

  arpr_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .req_ready (req_ready),
    .own_mac   (own_mac_r),
    .own_ip    (own_ip_r),
    .tgt_ip    (tgt_ip),
    .out_if    (out_if)
  );

endmodule
